// ----- hw/rtl/sais_pkg.sv -----
`timescale 1ns / 1ps

package sais_pkg;

  localparam int unsigned DefCapacity    = 64;
  localparam int unsigned DefPayloadBits = 32;

  localparam int unsigned KeyW    = 24;
  localparam int unsigned FuncW   = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned IndexW  = 6;
  localparam int unsigned CountW  = 7;

  typedef enum logic [FuncW-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_FIND   = 2'd1,
    FUNC_READ   = 2'd2
  } sais_func_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_MISS = 2'd2
  } sais_status_e;

  typedef struct packed {
    logic at_or_above;
    logic ge_valid;
    logic read_hit;
  } sais_flag_t;

endpackage

// ----- hw/rtl/sais_cell.sv -----
`timescale 1ns / 1ps

module sais_cell #(
  parameter int unsigned POS          = 0,
  parameter int unsigned PAYLOAD_BITS = sais_pkg::DefPayloadBits,
  parameter int unsigned CNT_W        = 7,
  parameter int unsigned SEL_W        = 6
) (
  input  logic                          clk_i,
  input  logic                          shift_en_i,
  input  logic [sais_pkg::KeyW-1:0]     key_i,
  input  logic [PAYLOAD_BITS-1:0]       payload_i,
  input  logic [CNT_W-1:0]              count_i,
  input  logic [SEL_W-1:0]              index_i,
  input  logic [sais_pkg::KeyW-1:0]     prev_key_i,
  input  logic [PAYLOAD_BITS-1:0]       prev_payload_i,
  input  sais_pkg::sais_flag_t          prev_flag_i,
  output logic [sais_pkg::KeyW-1:0]     key_o,
  output logic [PAYLOAD_BITS-1:0]       payload_o,
  output sais_pkg::sais_flag_t          flag_o,
  output logic [sais_pkg::KeyW-1:0]     rd_key_o,
  output logic [PAYLOAD_BITS-1:0]       rd_payload_o
);
  import sais_pkg::*;

  logic [KeyW-1:0]         key_q, key_d;
  logic [PAYLOAD_BITS-1:0] payload_q, payload_d;
  logic                    valid;
  logic                    ge;

  assign valid = CNT_W'(POS) < count_i;
  assign ge    = key_q >= key_i;

  assign flag_o.at_or_above = !valid || ge;
  assign flag_o.ge_valid    = valid && ge;
  assign flag_o.read_hit    = valid && (index_i == SEL_W'(POS));

  always_comb begin
    key_d     = key_q;
    payload_d = payload_q;
    if (shift_en_i && flag_o.at_or_above) begin
      if (prev_flag_i.at_or_above) begin
        key_d     = prev_key_i;
        payload_d = prev_payload_i;
      end else begin
        key_d     = key_i;
        payload_d = payload_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    payload_q <= payload_d;
  end

  assign key_o        = key_q;
  assign payload_o    = payload_q;
  assign rd_key_o     = flag_o.read_hit ? key_q : '0;
  assign rd_payload_o = flag_o.read_hit ? payload_q : '0;

endmodule

// ----- hw/rtl/sorted_array_insert_search.sv -----
// An accepted request's result is registered and shown in the next cycle.
// Throughput: one request per cycle while results are taken. In the same cycle
// every cell compares its key and, on an insert, cells from the new slot up shift.
// Reset clears the entry count and the output handshake; table contents stay
// undefined until written.
`timescale 1ns / 1ps

module sorted_array_insert_search #(
  parameter int unsigned CAPACITY     = sais_pkg::DefCapacity,
  parameter int unsigned PAYLOAD_BITS = sais_pkg::DefPayloadBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [sais_pkg::FuncW-1:0]     func_i,
  input  logic [sais_pkg::KeyW-1:0]      key_i,
  input  logic [PAYLOAD_BITS-1:0]        payload_i,
  input  logic [sais_pkg::IndexW-1:0]    index_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [sais_pkg::StatusW-1:0]   status_o,
  output logic [sais_pkg::IndexW-1:0]    found_index_o,
  output logic [sais_pkg::KeyW-1:0]      key_out_o,
  output logic [PAYLOAD_BITS-1:0]        payload_out_o,
  output logic [sais_pkg::CountW-1:0]    count_o
);
  import sais_pkg::*;

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned SEL_W = (IDX_W > IndexW) ? IDX_W : IndexW;

  logic [CNT_W-1:0]        count_q, count_d;
  logic                    out_valid_q;
  logic [StatusW-1:0]      status_q, status_d;
  logic [IndexW-1:0]       found_q, found_d;
  logic [KeyW-1:0]         kout_q, kout_d;
  logic [PAYLOAD_BITS-1:0] pout_q, pout_d;

  logic                    accept;
  logic                    full;
  logic                    shift_en;
  sais_func_e              func;
  logic [SEL_W-1:0]        index_ext;

  logic [KeyW-1:0]         cell_key [CAPACITY];
  logic [PAYLOAD_BITS-1:0] cell_payload [CAPACITY];
  sais_flag_t              cell_flag [CAPACITY];
  logic [KeyW-1:0]         cell_rd_key [CAPACITY];
  logic [PAYLOAD_BITS-1:0] cell_rd_payload [CAPACITY];

  logic [IDX_W-1:0]        pos;
  logic                    any_ge;
  logic                    any_rd;
  logic [KeyW-1:0]         rd_key;
  logic [PAYLOAD_BITS-1:0] rd_payload;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign func       = sais_func_e'(func_i);
  assign full       = count_q == CNT_W'(CAPACITY);
  assign shift_en   = accept && (func == FUNC_INSERT) && !full;
  assign index_ext  = SEL_W'(index_i);

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [KeyW-1:0]         prev_key;
    logic [PAYLOAD_BITS-1:0] prev_payload;
    sais_flag_t              prev_flag;

    if (g == 0) begin : g_head
      assign prev_key     = '0;
      assign prev_payload = '0;
      assign prev_flag    = '0;
    end else begin : g_link
      assign prev_key     = cell_key[g-1];
      assign prev_payload = cell_payload[g-1];
      assign prev_flag    = cell_flag[g-1];
    end

    sais_cell #(
      .POS          (g),
      .PAYLOAD_BITS (PAYLOAD_BITS),
      .CNT_W        (CNT_W),
      .SEL_W        (SEL_W)
    ) u_cell (
      .clk_i          (clk_i),
      .shift_en_i     (shift_en),
      .key_i          (key_i),
      .payload_i      (payload_i),
      .count_i        (count_q),
      .index_i        (index_ext),
      .prev_key_i     (prev_key),
      .prev_payload_i (prev_payload),
      .prev_flag_i    (prev_flag),
      .key_o          (cell_key[g]),
      .payload_o      (cell_payload[g]),
      .flag_o         (cell_flag[g]),
      .rd_key_o       (cell_rd_key[g]),
      .rd_payload_o   (cell_rd_payload[g])
    );
  end

  always_comb begin
    pos        = '0;
    any_ge     = 1'b0;
    any_rd     = 1'b0;
    rd_key     = '0;
    rd_payload = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_flag[i].at_or_above && (i == 0 || !cell_flag[(i == 0) ? 0 : i - 1].at_or_above))
      begin
        pos = pos | IDX_W'(i);
      end
      any_ge     = any_ge | cell_flag[i].ge_valid;
      any_rd     = any_rd | cell_flag[i].read_hit;
      rd_key     = rd_key | cell_rd_key[i];
      rd_payload = rd_payload | cell_rd_payload[i];
    end
  end

  always_comb begin
    count_d  = count_q;
    status_d = STATUS_MISS;
    found_d  = '0;
    kout_d   = '0;
    pout_d   = '0;
    unique case (func)
      FUNC_INSERT: begin
        if (full) begin
          status_d = STATUS_FULL;
        end else begin
          status_d = STATUS_OK;
          found_d  = IndexW'(pos);
          count_d  = count_q + CNT_W'(1);
        end
      end
      FUNC_FIND: begin
        if (any_ge) begin
          status_d = STATUS_OK;
          found_d  = IndexW'(pos);
        end
      end
      FUNC_READ: begin
        if (any_rd) begin
          status_d = STATUS_OK;
          kout_d   = rd_key;
          pout_d   = rd_payload;
        end
      end
      default: begin
        status_d = STATUS_MISS;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      found_q  <= found_d;
      kout_q   <= kout_d;
      pout_q   <= pout_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_index_o = found_q;
  assign key_out_o     = kout_q;
  assign payload_out_o = pout_q;
  assign count_o       = CountW'(count_q);

endmodule
